@@ src/ac3_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ac3_pkg
// Shared types and constants of the 3x3 ARGB convolution block.
// ----------------------------------------------------------------------------
package ac3_pkg;

  // Geometry
  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 4096;
  localparam int KERNEL_SIZE = 3;

  // Field widths
  localparam int PIX_W     = 32;
  localparam int OUT_COL_W = 11;
  localparam int ROW_W     = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 48;
  localparam int WCFG_W    = 12;
  localparam int HCFG_W    = 13;
  localparam int WEIGHT_W  = 16;

  // Fixed-point: Q4.12 weights
  localparam int FRAC_BITS = 12;

  // Register reset values (sharpen kernel: -455 around a centre of 7737)
  localparam logic [WCFG_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [HCFG_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [CFG_W-1:0]  W_EDGE_RST = 48'hFE39_FE39_FE39;
  localparam logic [CFG_W-1:0]  W_MID_RST  = 48'hFE39_1E39_FE39;

  typedef logic [PIX_W-1:0] argb_t;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_WEIGHTS_TOP   = 3'd2,
    REG_WEIGHTS_MID   = 3'd3,
    REG_WEIGHTS_BOT   = 3'd4
  } cfg_reg_t;

  // Per-pixel info travelling down the pipeline
  typedef struct packed {
    argb_t                pix;
    logic [OUT_COL_W-1:0] col;
    logic [ROW_W-1:0]     row;
    logic                 filt;   // window complete: emits filtered (col-1,row-1)
    logic                 bord;   // border pixel: passes through
  } info_t;

  // One result
  typedef struct packed {
    argb_t                pix;
    logic [OUT_COL_W-1:0] col;
    logic [ROW_W-1:0]     row;
    logic                 last;
  } res_t;

  // Window / product stage enables
  typedef struct packed {
    logic shift;
    logic load;
  } filt_ctrl_t;

endpackage

@@ src/ac3_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ac3_if
// Valid/ready channels of the convolution block: pixels in, results out,
// and the configuration write port.
// ----------------------------------------------------------------------------
interface ac3_in_if;
  logic                 valid;
  logic                 ready;
  logic [31:0]          pixel_in;
  logic                 frame_start;

  modport source (output valid, pixel_in, frame_start, input ready);
  modport sink   (input valid, pixel_in, frame_start, output ready);
endinterface

interface ac3_out_if;
  logic                 valid;
  logic                 ready;
  logic [31:0]          pixel_out;
  logic [10:0]          out_column;
  logic [11:0]          out_row;
  logic                 last_of_run;

  modport source (output valid, pixel_out, out_column, out_row, last_of_run,
                  input ready);
  modport sink   (input valid, pixel_out, out_column, out_row, last_of_run,
                  output ready);
endinterface

interface ac3_cfg_if;
  logic                 valid;
  logic                 ready;
  logic [2:0]           reg_index;
  logic [47:0]          wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

@@ src/argb_convolution_3x3.sv @@
`timescale 1ns / 1ps
// Path: a pixel goes through the line store read, the window and products
//   and the sums into the output slot, where its first result is presented.
// Throughput: one pixel per cycle while each pixel gives at most one result;
//   unless stalled; two results of a pixel hold the output stage until taken.
// Reset: synchronous, active low; clears pipeline valids, counters and
//   registers to their defaults. Line stores and the window are not cleared.
// ----------------------------------------------------------------------------
// argb_convolution_3x3
// Streaming 3x3 convolution of ARGB pixels with two line stores, border
// pass-through and position-tagged results.
// ----------------------------------------------------------------------------
module argb_convolution_3x3 #(
  parameter int MAX_WIDTH = ac3_pkg::MAX_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  ac3_in_if.sink     in_ch,
  ac3_out_if.source  out_ch,
  ac3_cfg_if.sink    cfg_ch
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = ac3_pkg::ROW_W;

  // Configuration
  logic [ac3_pkg::WCFG_W-1:0] width_r;
  logic [ac3_pkg::HCFG_W-1:0] height_r;
  logic [ac3_pkg::CFG_W-1:0]  w_top_r, w_mid_r, w_bot_r;
  logic                       run_r;

  // Position
  logic [COL_W-1:0] col_r, col_nxt, col_base, cur_col, w_last;
  logic [ROW_W-1:0] row_r, row_nxt, row_base, cur_row, h_last;
  logic [ROW_W:0]   row_inc;
  logic             wrap;

  // Line stores
  ac3_pkg::argb_t upper_mem [MAX_WIDTH];
  ac3_pkg::argb_t lower_mem [MAX_WIDTH];
  ac3_pkg::argb_t up_rd_r, lo_rd_r, fwd_up_r, fwd_lo_r, up_eff, lo_eff;
  logic           fwd_r, fwd_hit;

  // Pipeline
  logic            s1_v_r, s2_v_r, s3_v_r;
  ac3_pkg::info_t  s1_info_r, s2_info_r, s3_info_r, cur_info;
  logic [COL_W-1:0] s1_addr_r;
  logic            in_xfer, out_xfer, adv1, adv2, adv3;
  logic            s1_free, s2_free, s3_free, s4_can;

  // Output stage
  ac3_pkg::res_t   slot0_r, slot1_r, slot0_nxt, slot1_nxt, filt_res, bord_res;
  logic [1:0]      cnt_r, cnt_nxt;
  ac3_pkg::argb_t  filt_pix;
  ac3_pkg::filt_ctrl_t fctrl;

  // ---------------- configuration port ----------------
  assign cfg_ch.ready = run_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r    <= 1'b0;
      width_r  <= ac3_pkg::WIDTH_RST;
      height_r <= ac3_pkg::HEIGHT_RST;
      w_top_r  <= ac3_pkg::W_EDGE_RST;
      w_mid_r  <= ac3_pkg::W_MID_RST;
      w_bot_r  <= ac3_pkg::W_EDGE_RST;
    end else begin
      run_r <= 1'b1;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (ac3_pkg::cfg_reg_t'(cfg_ch.reg_index))
          ac3_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_ch.wdata[ac3_pkg::WCFG_W-1:0];
          ac3_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_ch.wdata[ac3_pkg::HCFG_W-1:0];
          ac3_pkg::REG_WEIGHTS_TOP:  w_top_r  <= cfg_ch.wdata;
          ac3_pkg::REG_WEIGHTS_MID:  w_mid_r  <= cfg_ch.wdata;
          ac3_pkg::REG_WEIGHTS_BOT:  w_bot_r  <= cfg_ch.wdata;
          default: ;
        endcase
      end
    end
  end

  // Clamped last column / last row
  always_comb begin
    if (width_r == '0) begin
      w_last = '0;
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_last = COL_W'(width_r - 12'd1);
    end
    if (height_r == '0) begin
      h_last = '0;
    end else if (32'(height_r) > 32'(ac3_pkg::MAX_HEIGHT)) begin
      h_last = ROW_W'(ac3_pkg::MAX_HEIGHT - 1);
    end else begin
      h_last = ROW_W'(height_r - 13'd1);
    end
  end

  // ---------------- position of the incoming pixel ----------------
  always_comb begin
    col_base = in_ch.frame_start ? '0 : col_r;
    row_base = in_ch.frame_start ? '0 : row_r;
    wrap     = col_base > w_last;
    cur_col  = wrap ? '0 : col_base;
    row_inc  = {1'b0, row_base} + (ROW_W + 1)'(wrap);
    cur_row  = (row_inc > {1'b0, h_last}) ? '0 : row_inc[ROW_W-1:0];

    if (cur_col == w_last) begin
      col_nxt = '0;
      row_nxt = (cur_row == h_last) ? '0 : cur_row + 1'b1;
    end else begin
      col_nxt = cur_col + 1'b1;
      row_nxt = cur_row;
    end

    cur_info.pix  = in_ch.pixel_in;
    cur_info.col  = ac3_pkg::OUT_COL_W'(cur_col);
    cur_info.row  = cur_row;
    cur_info.filt = (cur_col >= COL_W'(2)) && (cur_row >= ROW_W'(2));
    cur_info.bord = (cur_col == '0) || (cur_row == '0) ||
                    (cur_col == w_last) || (cur_row == h_last);
  end

  // ---------------- pipeline flow ----------------
  assign s4_can   = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ch.ready);
  assign s3_free  = !s3_v_r || s4_can;
  assign s2_free  = !s2_v_r || s3_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign adv3     = s3_v_r && s4_can;
  assign adv2     = s2_v_r && s3_free;
  assign adv1     = s1_v_r && s2_free;
  assign in_ch.ready = run_r && s1_free;
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      col_r  <= '0;
      row_r  <= '0;
    end else begin
      s1_v_r <= in_xfer || (s1_v_r && !adv1);
      s2_v_r <= adv1 || (s2_v_r && !adv2);
      s3_v_r <= adv2 || (s3_v_r && !adv3);
      if (in_xfer) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_info_r <= cur_info;
      s1_addr_r <= cur_col;
      fwd_r     <= fwd_hit;
      fwd_up_r  <= lo_eff;
      fwd_lo_r  <= s1_info_r.pix;
    end
    if (adv1) begin
      s2_info_r <= s1_info_r;
    end
    if (adv2) begin
      s3_info_r <= s2_info_r;
    end
  end

  // ---------------- line stores ----------------
  // A write to the column being read in the same cycle is forwarded.
  assign fwd_hit = adv1 && (s1_addr_r == cur_col);
  assign up_eff  = fwd_r ? fwd_up_r : up_rd_r;
  assign lo_eff  = fwd_r ? fwd_lo_r : lo_rd_r;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      up_rd_r <= upper_mem[cur_col];
      lo_rd_r <= lower_mem[cur_col];
    end
    if (adv1) begin
      upper_mem[s1_addr_r] <= lo_eff;
      lower_mem[s1_addr_r] <= s1_info_r.pix;
    end
  end

  // ---------------- filter datapath ----------------
  assign fctrl.shift = adv1;
  assign fctrl.load  = adv2;

  ac3_filter u_filter (
    .clk      (clk),
    .ctrl     (fctrl),
    .up_pix   (up_eff),
    .lo_pix   (lo_eff),
    .new_pix  (s1_info_r.pix),
    .w_top    (w_top_r),
    .w_mid    (w_mid_r),
    .w_bot    (w_bot_r),
    .filt_pix (filt_pix)
  );

  // ---------------- output stage: up to two results ----------------
  always_comb begin
    filt_res.pix  = filt_pix;
    filt_res.col  = s3_info_r.col - 1'b1;
    filt_res.row  = s3_info_r.row - 1'b1;
    filt_res.last = !s3_info_r.bord;
    bord_res.pix  = s3_info_r.pix;
    bord_res.col  = s3_info_r.col;
    bord_res.row  = s3_info_r.row;
    bord_res.last = 1'b1;

    cnt_nxt   = cnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (out_xfer) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end
    if (adv3) begin
      cnt_nxt   = 2'(s3_info_r.filt) + 2'(s3_info_r.bord);
      slot0_nxt = s3_info_r.filt ? filt_res : bord_res;
      slot1_nxt = bord_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign out_ch.valid       = (cnt_r != 2'd0);
  assign out_ch.pixel_out   = slot0_r.pix;
  assign out_ch.out_column  = slot0_r.col;
  assign out_ch.out_row     = slot0_r.row;
  assign out_ch.last_of_run = slot0_r.last;

endmodule

@@ src/ac3_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ac3_filter
// 3x3 pixel window, per-tap product register and channel sum with
// clamp-to-zero, round-half-up and saturation.
// ----------------------------------------------------------------------------
module ac3_filter (
  input  logic                     clk,
  input  ac3_pkg::filt_ctrl_t      ctrl,
  input  ac3_pkg::argb_t           up_pix,
  input  ac3_pkg::argb_t           lo_pix,
  input  ac3_pkg::argb_t           new_pix,
  input  logic [ac3_pkg::CFG_W-1:0] w_top,
  input  logic [ac3_pkg::CFG_W-1:0] w_mid,
  input  logic [ac3_pkg::CFG_W-1:0] w_bot,
  output ac3_pkg::argb_t           filt_pix
);

  localparam int K      = ac3_pkg::KERNEL_SIZE;
  localparam int PROD_W = 24;   // 9-bit unsigned x 16-bit signed, fits 24
  localparam int ACC_W  = 28;   // nine products
  localparam int Q_W    = ACC_W - ac3_pkg::FRAC_BITS;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1 << (ac3_pkg::FRAC_BITS - 1));

  ac3_pkg::argb_t           window_r [K][K];
  logic [ac3_pkg::CFG_W-1:0] w_rows   [K];
  logic signed [PROD_W-1:0] prod_nxt [K][K][3];
  logic signed [PROD_W-1:0] prod_r   [K][K][3];
  logic [7:0]               alpha_r;
  logic signed [ACC_W-1:0]  row_sum  [K][3];
  logic signed [ACC_W-1:0]  acc      [3];
  logic [7:0]               chan_out [3];

  // Negative -> 0, else (acc + half) >> 12 saturated to 255
  function automatic logic [7:0] finish_chan(input logic signed [ACC_W-1:0] a);
    logic [ACC_W-1:0] rnd;
    logic [Q_W-1:0]   q;
    begin
      rnd = a + HALF;
      q   = rnd[ACC_W-1:ac3_pkg::FRAC_BITS];
      if (a[ACC_W-1]) begin
        finish_chan = 8'd0;
      end else if (q > Q_W'(255)) begin
        finish_chan = 8'hFF;
      end else begin
        finish_chan = q[7:0];
      end
    end
  endfunction

  assign w_rows[0] = w_top;
  assign w_rows[1] = w_mid;
  assign w_rows[2] = w_bot;

  // Window: shift left, new column enters on the right
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      for (int i = 0; i < K; i++) begin
        window_r[i][0] <= window_r[i][1];
        window_r[i][1] <= window_r[i][2];
      end
      window_r[0][2] <= up_pix;
      window_r[1][2] <= lo_pix;
      window_r[2][2] <= new_pix;
    end
  end

  // Tap products; channel 0 red, 1 green, 2 blue
  always_comb begin
    for (int ky = 0; ky < K; ky++) begin
      for (int kx = 0; kx < K; kx++) begin
        for (int ch = 0; ch < 3; ch++) begin
          prod_nxt[ky][kx][ch] = PROD_W'(
            $signed({1'b0, window_r[ky][kx][(16 - 8 * ch) +: 8]}) *
            $signed(w_rows[ky][(ac3_pkg::WEIGHT_W * kx) +: ac3_pkg::WEIGHT_W]));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      prod_r  <= prod_nxt;
      alpha_r <= window_r[1][1][31:24];
    end
  end

  // Channel sums: per row, then over rows
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int ky = 0; ky < K; ky++) begin
        row_sum[ky][ch] = ACC_W'(prod_r[ky][0][ch]) + ACC_W'(prod_r[ky][1][ch])
                        + ACC_W'(prod_r[ky][2][ch]);
      end
      acc[ch]      = row_sum[0][ch] + row_sum[1][ch] + row_sum[2][ch];
      chan_out[ch] = finish_chan(acc[ch]);
    end
  end

  assign filt_pix = {alpha_r, chan_out[0], chan_out[1], chan_out[2]};

endmodule

@@ src/ac3_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ac3_checker
// Port-level checks of the convolution block, bound to the top level.
// ----------------------------------------------------------------------------
module ac3_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pixel,
  input logic [10:0] out_column,
  input logic [11:0] out_row,
  input logic        out_last
);

  // Reset empties the block and closes the input
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("ac3: output valid or input ready after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_pixel) && $stable(out_column) &&
      $stable(out_row) && $stable(out_last))
    else $error("ac3: stalled result changed");

  // The second result of a pixel is already buffered
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("ac3: second result of a pixel missing");

  // Filtered result is followed by the border pixel one column and row on
  a_pair_position: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_column == 11'($past(out_column) + 11'd1) &&
      out_row == 12'($past(out_row) + 12'd1))
    else $error("ac3: result pair positions do not match");

endmodule

bind argb_convolution_3x3 ac3_checker u_ac3_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_pixel  (out_ch.pixel_out),
  .out_column (out_ch.out_column),
  .out_row    (out_ch.out_row),
  .out_last   (out_ch.last_of_run)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3x3 ARGB convolution. A scoreboard class keeps
// its own line stores, window, position counters and kernel registers. It
// predicts the filtered and border pixels of every transfer, then checks the
// position-tagged results in order. A short directed run covers extreme
// pixels and weights, tiny frames, and a frame that shrinks while running.
// Random phases follow with random geometry, kernels and flow control.
// ----------------------------------------------------------------------------
module tb_top;

  // Predicts results from accepted pixels and checks the output stream
  class conv_result_board;
    ac3_pkg::argb_t                upper_line[ac3_pkg::MAX_WIDTH];
    ac3_pkg::argb_t                lower_line[ac3_pkg::MAX_WIDTH];
    ac3_pkg::argb_t                win[3][3];
    int unsigned                   col_pos;
    int unsigned                   row_pos;
    logic [ac3_pkg::WCFG_W-1:0]    width_reg;
    logic [ac3_pkg::HCFG_W-1:0]    height_reg;
    logic [ac3_pkg::CFG_W-1:0]     kernel_row[3];
    ac3_pkg::res_t                 pending_results[$];
    int                            errors;

    function new();
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        lower_line[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      col_pos       = 0;
      row_pos       = 0;
      width_reg     = ac3_pkg::WIDTH_RST;
      height_reg    = ac3_pkg::HEIGHT_RST;
      kernel_row[0] = ac3_pkg::W_EDGE_RST;
      kernel_row[1] = ac3_pkg::W_MID_RST;
      kernel_row[2] = ac3_pkg::W_EDGE_RST;
      errors        = 0;
    endfunction

    function void write_reg(ac3_pkg::cfg_reg_t idx, logic [ac3_pkg::CFG_W-1:0] data);
      case (idx)
        ac3_pkg::REG_IMAGE_WIDTH:  width_reg = data[ac3_pkg::WCFG_W-1:0];
        ac3_pkg::REG_IMAGE_HEIGHT: height_reg = data[ac3_pkg::HCFG_W-1:0];
        ac3_pkg::REG_WEIGHTS_TOP:  kernel_row[0] = data;
        ac3_pkg::REG_WEIGHTS_MID:  kernel_row[1] = data;
        ac3_pkg::REG_WEIGHTS_BOT:  kernel_row[2] = data;
        default: ;
      endcase
    endfunction

    // Negative sums clamp to zero, others round half up and saturate
    function logic [7:0] finish_channel(int acc);
      int v;
      if (acc < 0) return 8'd0;
      v = (acc + (1 << (ac3_pkg::FRAC_BITS - 1))) >>> ac3_pkg::FRAC_BITS;
      return (v > 255) ? 8'hFF : v[7:0];
    endfunction

    function ac3_pkg::argb_t filter_window();
      int               acc[3];
      logic signed [15:0] wt;
      int               chan;
      acc = '{0, 0, 0};
      for (int ky = 0; ky < 3; ky++) begin
        for (int kx = 0; kx < 3; kx++) begin
          wt = kernel_row[ky][ac3_pkg::WEIGHT_W*kx +: ac3_pkg::WEIGHT_W];
          for (int ch = 0; ch < 3; ch++) begin
            chan = win[ky][kx][16-8*ch +: 8];
            acc[ch] += chan * int'(wt);
          end
        end
      end
      return {win[1][1][31:24], finish_channel(acc[0]), finish_channel(acc[1]),
              finish_channel(acc[2])};
    endfunction

    function void note_pixel(ac3_pkg::argb_t pix, logic fs);
      int unsigned    w, h, c, r;
      ac3_pkg::argb_t up, lo;
      ac3_pkg::res_t  item;
      bit             filt, bord;
      w = width_reg;
      h = height_reg;
      if (w < 1) w = 1;
      if (w > ac3_pkg::MAX_WIDTH) w = ac3_pkg::MAX_WIDTH;
      if (h < 1) h = 1;
      if (h > ac3_pkg::MAX_HEIGHT) h = ac3_pkg::MAX_HEIGHT;

      // position, including a frame that shrank under the counters
      if (fs) begin
        col_pos = 0;
        row_pos = 0;
      end
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      c = col_pos;
      r = row_pos;

      // line stores and window
      up = upper_line[c];
      lo = lower_line[c];
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2]     = up;
      win[1][2]     = lo;
      win[2][2]     = pix;
      upper_line[c] = lo;
      lower_line[c] = pix;

      // filtered (c-1,r-1) first, then the border pixel itself
      filt = (c >= 2 && r >= 2);
      bord = (c == 0 || r == 0 || c == w - 1 || r == h - 1);
      if (filt) begin
        item.pix  = filter_window();
        item.col  = ac3_pkg::OUT_COL_W'(c - 1);
        item.row  = ac3_pkg::ROW_W'(r - 1);
        item.last = !bord;
        pending_results.push_back(item);
      end
      if (bord) begin
        item.pix  = pix;
        item.col  = ac3_pkg::OUT_COL_W'(c);
        item.row  = ac3_pkg::ROW_W'(r);
        item.last = 1'b1;
        pending_results.push_back(item);
      end

      col_pos = c + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = r + 1;
        if (row_pos >= h) row_pos = 0;
      end
    endfunction

    function void check_result(ac3_pkg::argb_t pix, logic [ac3_pkg::OUT_COL_W-1:0] col,
                               logic [ac3_pkg::ROW_W-1:0] row, logic last);
      ac3_pkg::res_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: pixel %h column %0d row %0d", pix, col, row);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (pix !== want.pix) begin
        $error("pixel_out: expected %h, actual %h", want.pix, pix);
        errors++;
      end
      if (col !== want.col) begin
        $error("out_column: expected %0d, actual %0d", want.col, col);
        errors++;
      end
      if (row !== want.row) begin
        $error("out_row: expected %0d, actual %0d", want.row, row);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %0b, actual %0b", want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;

  conv_result_board board = new();

  ac3_in_if  in_ch();
  ac3_out_if out_ch();
  ac3_cfg_if cfg_ch();

  argb_convolution_3x3 i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side back-pressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: every transfer on the three channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready)
        board.write_reg(ac3_pkg::cfg_reg_t'(cfg_ch.reg_index), cfg_ch.wdata);
      if (in_ch.valid && in_ch.ready)
        board.note_pixel(in_ch.pixel_in, in_ch.frame_start);
      if (out_ch.valid && out_ch.ready)
        board.check_result(out_ch.pixel_out, out_ch.out_column, out_ch.out_row,
                           out_ch.last_of_run);
    end
  end

  task automatic send_pixel(input ac3_pkg::argb_t pix, input logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.pixel_in    <= pix;
    in_ch.frame_start <= fs;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_reg(input ac3_pkg::cfg_reg_t idx,
                           input logic [ac3_pkg::CFG_W-1:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold the pixel stream until all results are out, then cover pipeline depth
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic reconfigure(input int w, input int h,
                             input logic [ac3_pkg::CFG_W-1:0] kt,
                             input logic [ac3_pkg::CFG_W-1:0] km,
                             input logic [ac3_pkg::CFG_W-1:0] kb);
    settle();
    write_reg(ac3_pkg::REG_IMAGE_WIDTH, ac3_pkg::CFG_W'(w));
    write_reg(ac3_pkg::REG_IMAGE_HEIGHT, ac3_pkg::CFG_W'(h));
    write_reg(ac3_pkg::REG_WEIGHTS_TOP, kt);
    write_reg(ac3_pkg::REG_WEIGHTS_MID, km);
    write_reg(ac3_pkg::REG_WEIGHTS_BOT, kb);
  endtask

  // Kernel styles: sharpen, raw random, mild positive, extremes, moderate signed
  function automatic logic [ac3_pkg::CFG_W-1:0] pick_kernel_row(input int style,
                                                               input int ky);
    logic [ac3_pkg::CFG_W-1:0]    row;
    logic [ac3_pkg::WEIGHT_W-1:0] tap;
    if (style == 0) return (ky == 1) ? ac3_pkg::W_MID_RST : ac3_pkg::W_EDGE_RST;
    if (style == 1) return ac3_pkg::CFG_W'({$urandom, $urandom});
    for (int kx = 0; kx < 3; kx++) begin
      case (style)
        2: tap = ac3_pkg::WEIGHT_W'($urandom_range(0, 'h600));
        3: begin
          case ($urandom_range(3))
            0:       tap = 16'h8000;
            1:       tap = 16'h7FFF;
            2:       tap = 16'h0000;
            default: tap = 16'h1000;
          endcase
        end
        default: tap = ac3_pkg::WEIGHT_W'(int'($urandom_range(0, 4096)) - 2048);
      endcase
      row[ac3_pkg::WEIGHT_W*kx +: ac3_pkg::WEIGHT_W] = tap;
    end
    return row;
  endfunction

  // Stimulus
  initial begin
    int   flen, budget, sent, rand_items, phase, w, h, style;
    bit   fresh, lead_start;
    logic fs;
    in_ch.valid       <= 1'b0;
    in_ch.pixel_in    <= '0;
    in_ch.frame_start <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.reg_index  <= ac3_pkg::REG_IMAGE_WIDTH;
    cfg_ch.wdata      <= '0;
    rst_n             <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 3x3 frame, full-scale checkerboard under extreme weights
    reconfigure(3, 3, 48'h8000_7FFF_8000, 48'h7FFF_8000_7FFF, 48'h0000_7FFF_8000);
    for (int i = 0; i < 9; i++)
      send_pixel((i == 4) ? 32'h5AFF_FFFF : ((i % 2 == 0) ? 32'hFFFF_FFFF : 32'h0),
                 i == 0);

    // 1x1 frame: each pixel is border, second one wraps without frame start
    reconfigure(1, 1, ac3_pkg::W_EDGE_RST, ac3_pkg::W_MID_RST, ac3_pkg::W_EDGE_RST);
    send_pixel($urandom, 1'b1);
    send_pixel($urandom, 1'b0);

    // Frame shrinks mid-row: the column falls outside the new size, then the row
    reconfigure(4, 6, ac3_pkg::W_EDGE_RST, ac3_pkg::W_MID_RST, ac3_pkg::W_EDGE_RST);
    for (int i = 0; i < 11; i++) send_pixel($urandom, i == 0);
    reconfigure(3, 3, ac3_pkg::W_EDGE_RST, ac3_pkg::W_MID_RST, ac3_pkg::W_EDGE_RST);
    send_pixel($urandom, 1'b0);
    send_pixel($urandom, 1'b0);

    // Random phases
    rand_items = 0;
    phase      = 0;
    while (rand_items < 1850) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase

      case ($urandom_range(9))
        0:       begin w = $urandom_range(1, 2);  h = $urandom_range(1, 6);  end
        1:       begin w = $urandom_range(3, 10); h = $urandom_range(1, 2);  end
        default: begin w = $urandom_range(3, 16); h = $urandom_range(3, 10); end
      endcase
      if ($urandom_range(15) == 0) h = ac3_pkg::MAX_HEIGHT;
      if ($urandom_range(15) == 0) begin w = 1; h = 1; end
      style = $urandom_range(4);
      reconfigure(w, h, pick_kernel_row(style, 0), pick_kernel_row(style, 1),
                  pick_kernel_row(style, 2));

      // whole frames mostly, some cut short, some run on without frame start
      budget = $urandom_range(60, 260);
      sent   = 0;
      fresh  = 1'b1;
      while (sent < budget) begin
        flen = w * h;
        if ($urandom_range(7) == 0) flen = $urandom_range(1, flen);
        lead_start = fresh || ($urandom_range(3) != 0);
        for (int i = 0; i < flen && sent < budget; i++) begin
          fs = (i == 0 && lead_start) || ($urandom_range(199) == 0);
          send_pixel($urandom, fs);
          sent++;
        end
        fresh = 1'b0;
      end
      rand_items += sent;
      phase++;
    end

    settle();
    if (board.errors == 0)
      $display("[argb_convolution_3x3] OK");
    else
      $display("[argb_convolution_3x3] ERROR");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("[argb_convolution_3x3] ERROR");
    $finish;
  end

endmodule
